// ===== rtl/core/blu2x_pkg.sv =====
// shared types and constants of the 2x bilinear upscaler
package blu2x_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int COORD_W     = 11;
  localparam int M_TDATA_W   = 48;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(316);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // red sits in the low byte so the struct maps straight onto tdata
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_t;

  // pixels of one item handed from the fetch stage to the output stage
  typedef struct packed {
    pix_t cur;
    pix_t left;
    pix_t above;
  } item_pix_t;

endpackage

// ===== rtl/core/blu2x_ram.sv =====
// generic single-port-write, registered-read ram (read-first)
module blu2x_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/blu2x_front.sv =====
// input stage: config registers, raster counters, line buffer access
module blu2x_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [blu2x_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blu2x_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  blu2x_pkg::pix_t               s_pix,
  output logic                          s1_valid,
  input  logic                          take,
  output blu2x_pkg::item_pix_t          s1_pix,
  output logic [RW-1:0]                 s1_row,
  output logic [AW-1:0]                 s1_col
);

  localparam int CWW = $clog2(MAX_WIDTH + 1);
  localparam int CWH = $clog2(MAX_HEIGHT + 1);
  localparam int XW  = AW + 1;
  localparam int XH  = RW + 1;

  logic [blu2x_pkg::CFG_W-1:0] image_width;
  logic [blu2x_pkg::CFG_W-1:0] image_height;
  logic [CWW-1:0]              w_eff;
  logic [CWH-1:0]              h_eff;
  logic [AW-1:0]               col_cnt;
  logic [RW-1:0]               row_cnt;
  logic [XW-1:0]               col_inc;
  logic [XH-1:0]               row_inc;
  blu2x_pkg::pix_t             left_pix;
  blu2x_pkg::pix_t             above_rd;
  blu2x_pkg::pix_t             cur_q;
  blu2x_pkg::pix_t             left_q;
  logic                        acc;

  always_comb begin
    if (image_width == '0) begin
      w_eff = CWW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = CWW'(MAX_WIDTH);
    end else begin
      w_eff = CWW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = CWH'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = CWH'(MAX_HEIGHT);
    end else begin
      h_eff = CWH'(image_height);
    end
  end

  assign s_tready = !s1_valid || take;
  assign acc      = s_tvalid && s_tready;
  assign col_inc  = {1'b0, col_cnt} + XW'(1);
  assign row_inc  = {1'b0, row_cnt} + XH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= blu2x_pkg::DIM_RESET;
      image_height <= blu2x_pkg::DIM_RESET;
      col_cnt      <= '0;
      row_cnt      <= '0;
      left_pix     <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          blu2x_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          blu2x_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
        col_cnt <= '0;
        row_cnt <= '0;
      end else if (acc) begin
        if (col_inc >= XW'(w_eff)) begin
          col_cnt <= '0;
          row_cnt <= (row_inc >= XH'(h_eff)) ? '0 : row_inc[RW-1:0];
        end else begin
          col_cnt <= col_inc[AW-1:0];
        end
      end
      if (acc) begin
        left_pix <= s_pix;
        s1_valid <= 1'b1;
      end else if (take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cur_q  <= s_pix;
      left_q <= left_pix;
      s1_row <= row_cnt;
      s1_col <= col_cnt;
    end
  end

  // read-first: the same-cycle write of this item does not disturb its read
  blu2x_ram #(
    .WIDTH (blu2x_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (acc),
    .waddr (col_cnt),
    .wdata (s_pix),
    .re    (acc),
    .raddr (col_cnt),
    .rdata (above_rd)
  );

  assign s1_pix = '{cur: cur_q, left: left_q, above: above_rd};

`ifndef SYNTHESIS
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    XW'(col_cnt) < XW'(w_eff))
    else $error("column counter beyond row width");
  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    XH'(row_cnt) < XH'(h_eff))
    else $error("row counter beyond frame height");
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !take) |=> (s1_valid && $stable(s1_row) && $stable(s1_col)))
    else $error("waiting item changed before it was taken");
`endif

endmodule

// ===== rtl/core/blu2x_emit.sv =====
// output stage: neighbor means and serialization of up to four pixels
module blu2x_emit #(
  parameter int RW = 10,
  parameter int AW = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s1_valid,
  output logic                          take,
  input  blu2x_pkg::item_pix_t          s1_pix,
  input  logic [RW-1:0]                 s1_row,
  input  logic [AW-1:0]                 s1_col,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [blu2x_pkg::COORD_W-1:0] out_row,
  output logic [blu2x_pkg::COORD_W-1:0] out_col,
  output blu2x_pkg::pix_t               out_pix,
  output logic                          m_tlast
);

  typedef enum logic [1:0] {
    K_CENTER = 2'd0,
    K_VERT   = 2'd1,
    K_HORIZ  = 2'd2,
    K_ORIG   = 2'd3
  } kind_t;

  function automatic blu2x_pkg::pix_t mean_pix(blu2x_pkg::pix_t a, blu2x_pkg::pix_t b);
    blu2x_pkg::pix_t r;
    logic [blu2x_pkg::CH_W:0] sr, sg, sb;
    sr = {1'b0, a.red}   + {1'b0, b.red};
    sg = {1'b0, a.green} + {1'b0, b.green};
    sb = {1'b0, a.blue}  + {1'b0, b.blue};
    r.red   = sr[blu2x_pkg::CH_W:1];
    r.green = sg[blu2x_pkg::CH_W:1];
    r.blue  = sb[blu2x_pkg::CH_W:1];
    return r;
  endfunction

  blu2x_pkg::pix_t pix_q [4];
  blu2x_pkg::pix_t above_left;
  blu2x_pkg::pix_t top_m, bot_m;
  logic [3:0]      pending;
  logic [RW-1:0]   row_q;
  logic [AW-1:0]   col_q;
  logic            last;
  kind_t           kind;
  logic [RW:0]     two_i;
  logic [AW:0]     two_j;

  assign m_tvalid = |pending;
  assign last     = $onehot(pending);
  assign m_tlast  = last;
  assign take     = s1_valid && (!m_tvalid || (m_tready && last));

  assign top_m = mean_pix(above_left, s1_pix.above);
  assign bot_m = mean_pix(s1_pix.left, s1_pix.cur);

  always_comb begin
    priority if (pending[K_CENTER]) begin
      kind = K_CENTER;
    end else if (pending[K_VERT]) begin
      kind = K_VERT;
    end else if (pending[K_HORIZ]) begin
      kind = K_HORIZ;
    end else begin
      kind = K_ORIG;
    end
  end

  assign two_i   = {row_q, 1'b0};
  assign two_j   = {col_q, 1'b0};
  assign out_row = blu2x_pkg::COORD_W'(two_i)
                 - ((kind == K_CENTER || kind == K_VERT) ? 11'd1 : 11'd0);
  assign out_col = blu2x_pkg::COORD_W'(two_j)
                 - ((kind == K_CENTER || kind == K_HORIZ) ? 11'd1 : 11'd0);
  assign out_pix = pix_q[kind];

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      above_left <= '0;
    end else if (take) begin
      above_left        <= s1_pix.above;
      pending[K_CENTER] <= (s1_row != '0) && (s1_col != '0);
      pending[K_VERT]   <= (s1_row != '0);
      pending[K_HORIZ]  <= (s1_col != '0);
      pending[K_ORIG]   <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      pending[kind] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_q[K_CENTER] <= mean_pix(top_m, bot_m);
      pix_q[K_VERT]   <= mean_pix(s1_pix.above, s1_pix.cur);
      pix_q[K_HORIZ]  <= bot_m;
      pix_q[K_ORIG]   <= s1_pix.cur;
      row_q           <= s1_row;
      col_q           <= s1_col;
    end
  end

`ifndef SYNTHESIS
  a_orig_loaded: assert property (@(posedge clk) disable iff (rst)
    take |=> pending[K_ORIG])
    else $error("original pixel missing after load");
  a_center_order: assert property (@(posedge clk) disable iff (rst)
    pending[K_CENTER] |-> (pending[K_VERT] && pending[K_HORIZ]))
    else $error("center pixel pending without both edge means");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (take && m_tvalid) |-> (m_tready && last))
    else $error("new item loaded over pending results");
`endif

endmodule

// ===== rtl/core/bilinear_upscale_2x_unit.sv =====
// top level of the 2x bilinear upscaler for an rgb raster stream
//
//  port group  | dir | transfer rule          | payload
//  ------------+-----+------------------------+------------------------------------
//  cfg_*       | in  | cfg_we high            | cfg_index selects width/height
//  s_*         | in  | s_tvalid & s_tready    | one input pixel, raster order
//  m_*         | out | m_tvalid & m_tready    | one upscaled pixel with position
//
// each input pixel yields one to four output pixels, one output transfer per
// cycle while m_tready is high; the output stage's result count sets the pace
// input to first output passes the line buffer read, then the output register
// the next pixel is taken while the current one is still being emitted
// rst is synchronous; counters, left pixels and config return to defaults,
// the line buffer is not cleared and holds nothing valid until a row is written
// a stall on m_tready holds the output and backs up into s_tready
module bilinear_upscale_2x_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [blu2x_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blu2x_pkg::CFG_W-1:0]       cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [blu2x_pkg::PIX_W-1:0]       s_tdata,   // red_in, green_in, blue_in
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [blu2x_pkg::M_TDATA_W-1:0]   m_tdata,   // out_row, out_col, red_out,
                                                       // green_out, blue_out, zero pad
  output logic                              m_tlast    // run_end
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // fetch stage to output stage
  logic                          s1_valid;
  logic                          take;
  blu2x_pkg::item_pix_t          s1_pix;
  logic [RW-1:0]                 s1_row;
  logic [AW-1:0]                 s1_col;

  // output fields
  logic [blu2x_pkg::COORD_W-1:0] out_row;
  logic [blu2x_pkg::COORD_W-1:0] out_col;
  blu2x_pkg::pix_t               out_pix;

  // counters, config and line buffer; the buffer is written at the
  // transfer and read back in the same cycle, old data first
  blu2x_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_pix     (blu2x_pkg::pix_t'(s_tdata)),
    .s1_valid  (s1_valid),
    .take      (take),
    .s1_pix    (s1_pix),
    .s1_row    (s1_row),
    .s1_col    (s1_col)
  );

  // means are formed when the item loads; results leave lowest kind first
  blu2x_emit #(
    .RW (RW),
    .AW (AW)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .take     (take),
    .s1_pix   (s1_pix),
    .s1_row   (s1_row),
    .s1_col   (s1_col),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_row  (out_row),
    .out_col  (out_col),
    .out_pix  (out_pix),
    .m_tlast  (m_tlast)
  );

  // pixel struct already carries red in the low byte
  assign m_tdata = {2'b00, out_pix, out_col, out_row};

endmodule

// ===== tb/sv/tb_bilinear_upscale_2x_unit.sv =====
`timescale 1ns / 100ps
// testbench of the 2x bilinear upscaler: directed and random pixel streams checked against a predictor
module tb_bilinear_upscale_2x_unit;
  import blu2x_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int RANDOM_ITEMS = 330;
  localparam int QUIET_LIMIT  = 2000;   // cycles with no transfer on either stream
  localparam int END_WAIT     = 8;      // extra wait after the drain, as margin
  localparam int SHOWN_FAILS  = 10;

  // who inserts bubbles: nobody, the pixel source, the pixel sink, or both lightly
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // one pixel of the upscaled image as it should leave the block
  typedef struct {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    pix_t               pix;
    logic               last;
  } up_pixel_t;

  // tracks the upscaler state and the output pixels still owed by the block
  class upscale_tracker;
    pix_t             line_buf [MAX_W];
    pix_t             left_pix;
    pix_t             above_left_pix;
    int unsigned      col;
    int unsigned      row;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    up_pixel_t        due_pixels [$];
    int unsigned      failures;

    function new();
      left_pix       = '0;
      above_left_pix = '0;
      col            = 0;
      row            = 0;
      width_reg      = DIM_RESET;
      height_reg     = DIM_RESET;
      failures       = 0;
    endfunction

    // zero acts as one, anything past the buffer size as the buffer size
    function int unsigned active_dim(logic [CFG_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    // per-channel floored mean
    function pix_t mean(pix_t a, pix_t b);
      logic [CH_W:0] s;
      pix_t m;
      s = a.red + b.red;
      m.red = s[CH_W:1];
      s = a.green + b.green;
      m.green = s[CH_W:1];
      s = a.blue + b.blue;
      m.blue = s[CH_W:1];
      return m;
    endfunction

    function void add_pixel(int unsigned r, int unsigned c, pix_t p, logic last);
      due_pixels.push_back('{row: COORD_W'(r), col: COORD_W'(c), pix: p, last: last});
    endfunction

    // either register write restarts the frame
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
      col = 0;
      row = 0;
    endfunction

    // an input pixel was taken: queue the one to four pixels it produces
    function void note_pixel(pix_t cur);
      int unsigned w;
      int unsigned h;
      pix_t above;
      w = active_dim(width_reg, MAX_W);
      h = active_dim(height_reg, MAX_H);
      above = line_buf[col];
      if (row > 0 && col > 0)
        add_pixel(2 * row - 1, 2 * col - 1,
                  mean(mean(above_left_pix, above), mean(left_pix, cur)), 1'b0);
      if (row > 0) add_pixel(2 * row - 1, 2 * col, mean(above, cur), 1'b0);
      if (col > 0) add_pixel(2 * row, 2 * col - 1, mean(left_pix, cur), 1'b0);
      add_pixel(2 * row, 2 * col, cur, 1'b1);
      above_left_pix = above;
      left_pix = cur;
      line_buf[col] = cur;
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void check_pixel(logic [M_TDATA_W-1:0] data, logic last);
      up_pixel_t want;
      logic [COORD_W-1:0] got_row;
      logic [COORD_W-1:0] got_col;
      pix_t got_pix;
      logic [M_TDATA_W-2*COORD_W-PIX_W-1:0] got_pad;
      got_row = data[0 +: COORD_W];
      got_col = data[COORD_W +: COORD_W];
      got_pix = data[2 * COORD_W +: PIX_W];
      got_pad = data[M_TDATA_W-1 : 2 * COORD_W + PIX_W];
      if (due_pixels.size() == 0) begin
        failures++;
        if (failures <= SHOWN_FAILS)
          $display("unexpected output pixel: row %0d col %0d rgb %02h %02h %02h last %0b",
                   got_row, got_col, got_pix.red, got_pix.green, got_pix.blue, last);
        return;
      end
      want = due_pixels.pop_front();
      if (got_row !== want.row || got_col !== want.col || got_pix.red !== want.pix.red ||
          got_pix.green !== want.pix.green || got_pix.blue !== want.pix.blue ||
          last !== want.last || got_pad !== '0) begin
        failures++;
        if (failures <= SHOWN_FAILS)
          $display("mismatch: exp row %0d col %0d rgb %02h %02h %02h last %0b | got row %0d col %0d rgb %02h %02h %02h last %0b pad %0h",
                   want.row, want.col, want.pix.red, want.pix.green, want.pix.blue,
                   want.last, got_row, got_col, got_pix.red, got_pix.green, got_pix.blue,
                   last, got_pad);
      end
    endfunction

    function int unsigned pending();
      return due_pixels.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [PIX_W-1:0]     s_tdata   = '0;   // red_in, green_in, blue_in
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;          // out_row, out_col, red_out, green_out, blue_out, pad
  logic                 m_tlast;          // run_end

  idle_mode_t     idle_mode    = IDLE_NONE;
  int unsigned    quiet_cycles = 0;
  upscale_tracker tracker      = new();

  bilinear_upscale_2x_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // random bubble decision for the current idle pattern
  function automatic bit hold_off(bit sender_side);
    int unsigned pct;
    pct = 0;
    if (idle_mode == IDLE_SENDER && sender_side) pct = 60;
    if (idle_mode == IDLE_RECEIVER && !sender_side) pct = 60;
    if (idle_mode == IDLE_BOTH) pct = 6;
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic pix_t mk_pix(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    pix_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    return p;
  endfunction

  // channels lean toward the rails so odd sums and full-scale values show up often
  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic pix_t rand_pixel();
    return mk_pix(rand_chan(), rand_chan(), rand_chan());
  endfunction

  // mostly small frames; now and then zero or past the buffer size
  function automatic logic [CFG_W-1:0] pick_dim(int unsigned typical, int unsigned lim);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'($urandom_range(lim + 1, (1 << CFG_W) - 1));
      default: return CFG_W'($urandom_range(1, typical));
    endcase
  endfunction

  // output sink: check each transfer, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_pixel(m_tdata, m_tlast);
    m_tready <= !hold_off(1'b0);
  end

  // watchdog on stretches without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // one input transfer; valid stays up between back-to-back pixels
  task automatic send_pixel(input pix_t pix);
    if (hold_off(1'b1)) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while (hold_off(1'b1));
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    tracker.note_pixel(pix);
  endtask

  // stop sending until every owed output pixel has been seen
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // both registers, back to back, only with the block empty
  task automatic write_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    tracker.set_reg(REG_IMAGE_WIDTH, w);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    tracker.set_reg(REG_IMAGE_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned n_sent;
    int unsigned n_phase;
    int unsigned n_items;
    logic [CFG_W-1:0] w_val;
    logic [CFG_W-1:0] h_val;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset dimensions, top row only
    idle_mode = IDLE_BOTH;
    send_pixel(mk_pix(8'h00, 8'h00, 8'h00));
    send_pixel(mk_pix(8'hff, 8'hff, 8'hff));
    send_pixel(mk_pix(8'hff, 8'h00, 8'h80));

    // 2x2 frame plus two more to see the frame wrap; odd sums floor
    write_dims(11'd2, 11'd2);
    send_pixel(mk_pix(8'hff, 8'hff, 8'hff));
    send_pixel(mk_pix(8'h00, 8'h00, 8'h00));
    send_pixel(mk_pix(8'h00, 8'hff, 8'h01));
    send_pixel(mk_pix(8'hff, 8'h00, 8'hfe));
    send_pixel(mk_pix(8'h01, 8'h01, 8'h01));
    send_pixel(mk_pix(8'hfe, 8'hfe, 8'hfe));

    // zero dimensions act as one: every pixel is a frame of its own
    write_dims(11'd0, 11'd0);
    send_pixel(mk_pix(8'h55, 8'haa, 8'h55));
    send_pixel(mk_pix(8'haa, 8'h55, 8'haa));
    send_pixel(mk_pix(8'hff, 8'hff, 8'hff));

    // single column: only vertical means
    write_dims(11'd1, 11'd3);
    send_pixel(mk_pix(8'hff, 8'h00, 8'h7f));
    send_pixel(mk_pix(8'h00, 8'hff, 8'h80));
    send_pixel(mk_pix(8'hff, 8'hff, 8'hff));
    send_pixel(mk_pix(8'h00, 8'h00, 8'h00));

    // random phases: small frames mostly, random restarts, rotating idle patterns
    n_sent = 0;
    n_phase = 0;
    while (n_sent < RANDOM_ITEMS) begin
      idle_mode = idle_mode_t'(n_phase % 4);
      w_val = pick_dim(8, MAX_W);
      h_val = pick_dim(6, MAX_H);
      write_dims(w_val, h_val);
      n_items = $urandom_range(10, 60);
      repeat (n_items) begin
        if ($urandom_range(0, 39) == 0) drain();
        send_pixel(rand_pixel());
      end
      n_sent += n_items;
      n_phase++;
    end

    drain();
    repeat (END_WAIT) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/blu2x_pkg.sv
rtl/core/blu2x_ram.sv
rtl/core/blu2x_front.sv
rtl/core/blu2x_emit.sv
rtl/core/bilinear_upscale_2x_unit.sv
tb/sv/tb_bilinear_upscale_2x_unit.sv
